FILE: sv/suc_pkg.sv
package suc_pkg;

	localparam int SAMPLE_BITS_DEF     = 24;
	localparam int GAIN_TABLE_BITS_DEF = 10;

	localparam int CFG_DATA_BITS  = 24;
	localparam int CFG_INDEX_BITS = 2;
	localparam int COEFF_BITS     = 24;
	localparam int ENV_BITS       = 32;
	localparam int GAIN_BITS      = 17;

	// shared multiplier: A takes the envelope difference or the sample, B the pole or the gain
	localparam int MUL_A_BITS = ENV_BITS + 1;
	localparam int MUL_B_BITS = COEFF_BITS + 1;
	localparam int PROD_BITS  = MUL_A_BITS + MUL_B_BITS;

	localparam logic [CFG_INDEX_BITS-1:0] REG_MODE    = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_ATTACK  = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_RELEASE = 2'd2;

	localparam logic [1:0] MODE_BYPASS = 2'd0;

	localparam logic [COEFF_BITS-1:0] ATTACK_RESET  = 24'd16707456;
	localparam logic [COEFF_BITS-1:0] RELEASE_RESET = 24'd16776342;

	// thresholds in Q1.31
	localparam logic [ENV_BITS-1:0] THR_LIGHT = 32'd966367642;
	localparam logic [ENV_BITS-1:0] THR_HEAVY = 32'd1395864371;

	// makeup gains in Q5.12
	localparam logic [GAIN_BITS-1:0] MAKEUP_LIGHT = 17'd2867;
	localparam logic [GAIN_BITS-1:0] MAKEUP_HEAVY = 17'd2048;

	localparam longint unsigned Q30_ONE  = 64'd1 << 30;
	localparam longint unsigned LN10_Q30 = 64'd2472381918;

	// restoring shift-and-subtract quotient, used while building the gain table
	function automatic longint unsigned udiv64(longint unsigned num, longint unsigned den);
		longint unsigned quo;
		longint unsigned rem;
		quo = 64'd0;
		rem = 64'd0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[62:0], num[i]};
			if (rem >= den) begin
				rem = rem - den;
				quo[i] = 1'b1;
			end
		end
		return quo;
	endfunction

	// One table entry: boost from a Taylor series of exp, capped, times makeup; Q5.12
	function automatic logic [GAIN_BITS-1:0] gain_entry(longint unsigned idx, bit heavy,
			int table_bits);
		longint unsigned z;
		longint unsigned sum;
		longint unsigned term;
		longint unsigned g;
		longint unsigned cap;
		longint unsigned makeup;
		longint unsigned k;
		bit done;
		if (heavy) begin
			z = udiv64(idx * LN10_Q30 * 64'd17, 64'd12) >> table_bits;
			cap = 64'd20 << 12;
			makeup = 64'd2048;
		end else begin
			z = ((idx * LN10_Q30 * 64'd21) >> 4) >> table_bits;
			cap = 64'd12 << 12;
			makeup = 64'd2867;
		end
		sum = Q30_ONE;
		term = Q30_ONE;
		done = 1'b0;
		for (k = 1; k <= 24; k++) begin
			if (!done) begin
				term = udiv64((term * z) >> 30, k);
				if (term == 0)
					done = 1'b1;
				else
					sum = sum + term;
			end
		end
		g = (sum + (64'd1 << 17)) >> 18;
		if (g > cap)
			g = cap;
		return GAIN_BITS'((g * makeup + 64'd2048) >> 12);
	endfunction

endpackage

FILE: sv/suc_gain_rom.sv
module suc_gain_rom #(
	parameter int TABLE_BITS = suc_pkg::GAIN_TABLE_BITS_DEF
) (
	input  logic                         clk,
	input  logic [TABLE_BITS:0]          addr,
	output logic [suc_pkg::GAIN_BITS-1:0] data
);
	import suc_pkg::*;

	localparam int DEPTH   = 2 ** (TABLE_BITS + 1);
	localparam int LO_BITS = TABLE_BITS >> 1;
	localparam int HI_BITS = TABLE_BITS - LO_BITS;

	typedef logic [GAIN_BITS-1:0] rom_t [DEPTH];

	// lower half light mode, upper half heavy mode
	function automatic rom_t build_rom();
		rom_t r;
		for (int h = 0; h < 2; h++) begin
			for (int hi = 0; hi < (1 << HI_BITS); hi++) begin
				for (int lo = 0; lo < (1 << LO_BITS); lo++) begin
					r[(h << TABLE_BITS) | (hi << LO_BITS) | lo] =
						gain_entry(longint'((hi << LO_BITS) | lo), h != 0, TABLE_BITS);
				end
			end
		end
		return r;
	endfunction

	localparam rom_t ROM = build_rom();

	logic [GAIN_BITS-1:0] data_q;

	always_ff @(posedge clk) begin
		data_q <= ROM[addr];
	end

	assign data = data_q;

endmodule

FILE: sv/suc_mul.sv
module suc_mul (
	input  logic                                 clk,
	input  logic signed [suc_pkg::MUL_A_BITS-1:0] a,
	input  logic signed [suc_pkg::MUL_B_BITS-1:0] b,
	output logic signed [suc_pkg::PROD_BITS-1:0]  prod
);
	import suc_pkg::*;

	logic signed [PROD_BITS-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= PROD_BITS'(a) * PROD_BITS'(b);
	end

	assign prod = prod_q;

endmodule

FILE: sv/stereo_upward_compressor.sv
// Stereo upward compressor with attack/release envelope followers.
// Input channel: in_valid / in_stall carries one stereo pair (left_sample, right_sample).
// Output channel: out_valid / out_stall carries the processed pair (left_out, right_out).
// A transaction completes on a rising edge with valid high and stall low.
// Configuration: cfg_wr_en writes cfg_data into register cfg_index (0 mode,
// 1 attack pole, 2 release pole); other indexes are dropped. Write only while idle.
// In bypass mode a pair is accepted, copied and presented straight from the
// done state, and a new pair is taken once the block is back in idle;
// in the compressing modes each channel runs five steps through one shared
// multiplier (envelope product, envelope update, gain table read, gain product,
// saturation), so a pair is presented once both channels are through, and a new
// pair is taken only after the previous one has left for the output register.
// The steps run in turn because the multiplier is shared and the table registered.
// in_stall is high whenever a pair is in work. A finished pair waits in the
// output register while out_stall is high; the next pair can be accepted in
// the meantime but holds at its last step until the output register frees.
// Reset clears both envelopes, sets mode to bypass and loads the default poles.
module stereo_upward_compressor #(
	parameter int SAMPLE_BITS     = suc_pkg::SAMPLE_BITS_DEF,
	parameter int GAIN_TABLE_BITS = suc_pkg::GAIN_TABLE_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic [suc_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [suc_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [SAMPLE_BITS-1:0]        left_sample,
	input  logic signed [SAMPLE_BITS-1:0]        right_sample,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [SAMPLE_BITS-1:0]        left_out,
	output logic signed [SAMPLE_BITS-1:0]        right_out
);
	import suc_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE    = 7'b0000001,
		ST_MUL_ENV = 7'b0000010,
		ST_UPD     = 7'b0000100,
		ST_LOOK    = 7'b0001000,
		ST_MUL_OUT = 7'b0010000,
		ST_SAT     = 7'b0100000,
		ST_DONE    = 7'b1000000
	} state_t;

	localparam int Q_BITS = PROD_BITS - 12;

	state_t                      state_q;
	logic                        ch_q;
	logic                        heavy_q;
	logic                        below_q;
	logic [1:0]                  mode_q;
	logic [COEFF_BITS-1:0]       attack_q;
	logic [COEFF_BITS-1:0]       release_q;
	logic [ENV_BITS-1:0]         env_q [2];
	logic [ENV_BITS-1:0]         mag_q [2];
	logic signed [SAMPLE_BITS-1:0] smp_q [2];
	logic signed [SAMPLE_BITS-1:0] res_q [2];
	logic signed [SAMPLE_BITS-1:0] out_l_q;
	logic signed [SAMPLE_BITS-1:0] out_r_q;
	logic                        out_valid_q;

	logic                        in_fire;
	logic                        out_free;
	logic [SAMPLE_BITS-1:0]      abs_l;
	logic [SAMPLE_BITS-1:0]      abs_r;
	logic [ENV_BITS-1:0]         env_cur;
	logic [ENV_BITS-1:0]         mag_cur;
	logic [COEFF_BITS-1:0]       coeff;
	logic signed [MUL_A_BITS-1:0] mul_a;
	logic signed [MUL_B_BITS-1:0] mul_b;
	logic signed [PROD_BITS-1:0] prod;
	logic signed [PROD_BITS-1:0] acc;
	logic [ENV_BITS-1:0]         thr;
	logic [ENV_BITS-1:0]         dlt;
	logic [GAIN_TABLE_BITS:0]    rom_addr;
	logic [GAIN_BITS-1:0]        rom_data;
	logic [GAIN_BITS-1:0]        gain;
	logic signed [PROD_BITS-1:0] rnd;
	logic signed [Q_BITS-1:0]    q;
	logic                        q_fits;
	logic signed [SAMPLE_BITS-1:0] q_sat;

	assign in_fire  = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	assign abs_l = left_sample[SAMPLE_BITS-1]  ? SAMPLE_BITS'(-left_sample)  : left_sample;
	assign abs_r = right_sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(-right_sample) : right_sample;

	assign env_cur = env_q[ch_q];
	assign mag_cur = mag_q[ch_q];
	assign coeff   = (mag_cur > env_cur) ? attack_q : release_q;

	// c*env + (1-c)*mag folded into c*(env-mag) + mag
	always_comb begin
		if (state_q == ST_MUL_OUT) begin
			mul_a = MUL_A_BITS'(smp_q[ch_q]);
			mul_b = signed'(MUL_B_BITS'(gain));
		end else begin
			mul_a = signed'({1'b0, env_cur} - {1'b0, mag_cur});
			mul_b = signed'({1'b0, coeff});
		end
	end

	suc_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	assign acc = prod + signed'({2'b00, mag_cur, 24'b0});

	assign thr      = heavy_q ? THR_HEAVY : THR_LIGHT;
	assign dlt      = thr - env_cur;
	assign rom_addr = {heavy_q, dlt[30 -: GAIN_TABLE_BITS]};

	suc_gain_rom #(
		.TABLE_BITS (GAIN_TABLE_BITS)
	) u_rom (
		.clk  (clk),
		.addr (rom_addr),
		.data (rom_data)
	);

	assign gain = below_q ? rom_data : (heavy_q ? MAKEUP_HEAVY : MAKEUP_LIGHT);

	// round half up, then clamp to full scale
	assign rnd    = prod + PROD_BITS'(2048);
	assign q      = rnd[PROD_BITS-1:12];
	assign q_fits = (&q[Q_BITS-1:SAMPLE_BITS-1]) || !(|q[Q_BITS-1:SAMPLE_BITS-1]);
	always_comb begin
		if (q_fits)
			q_sat = q[SAMPLE_BITS-1:0];
		else if (q[Q_BITS-1])
			q_sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
		else
			q_sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_BYPASS;
			attack_q  <= ATTACK_RESET;
			release_q <= RELEASE_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_MODE:    mode_q    <= cfg_data[1:0];
				REG_ATTACK:  attack_q  <= cfg_data[COEFF_BITS-1:0];
				REG_RELEASE: release_q <= cfg_data[COEFF_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ch_q        <= 1'b0;
			heavy_q     <= 1'b0;
			below_q     <= 1'b0;
			out_valid_q <= 1'b0;
			env_q[0]    <= '0;
			env_q[1]    <= '0;
		end else begin
			// load on a finished pair, drop once the transaction completes
			if (state_q == ST_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						ch_q    <= 1'b0;
						heavy_q <= mode_q[1];
						state_q <= (mode_q == MODE_BYPASS) ? ST_DONE : ST_MUL_ENV;
					end
				end
				ST_MUL_ENV: state_q <= ST_UPD;
				ST_UPD: begin
					env_q[ch_q] <= acc[55:24];
					state_q     <= ST_LOOK;
				end
				ST_LOOK: begin
					below_q <= (env_cur < thr);
					state_q <= ST_MUL_OUT;
				end
				ST_MUL_OUT: state_q <= ST_SAT;
				ST_SAT: begin
					ch_q    <= 1'b1;
					state_q <= ch_q ? ST_DONE : ST_MUL_ENV;
				end
				ST_DONE: begin
					// hold until the output register is free
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			smp_q[0] <= left_sample;
			smp_q[1] <= right_sample;
			mag_q[0] <= ENV_BITS'(abs_l) << (ENV_BITS - SAMPLE_BITS);
			mag_q[1] <= ENV_BITS'(abs_r) << (ENV_BITS - SAMPLE_BITS);
			res_q[0] <= left_sample;
			res_q[1] <= right_sample;
		end
		if (state_q == ST_SAT)
			res_q[ch_q] <= q_sat;
		if (state_q == ST_DONE && out_free) begin
			out_l_q <= res_q[0];
			out_r_q <= res_q[1];
		end
	end

	assign out_valid = out_valid_q;
	assign left_out  = out_l_q;
	assign right_out = out_r_q;

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result presented without finishing a pair");

	a_bypass_direct: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && mode_q == MODE_BYPASS) |=> (state_q == ST_DONE))
		else $error("bypass pair did not go straight to output");

	a_env_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_UPD) |=> $stable({env_q[1], env_q[0]}))
		else $error("envelope changed outside the update step");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_valid_q && out_stall) |=> (state_q == ST_DONE))
		else $error("pending result overwritten");

endmodule

FILE: test/tb_top.sv
module tb_top;
	import suc_pkg::*;

	localparam int SAMPLE_BITS     = 24;
	localparam int GAIN_TABLE_BITS = 10;
	localparam int CYCLE_LIMIT     = 200000;
	localparam int SETTLE_CYCLES   = 16;
	localparam int HOLD_CYCLES     = 300;

	localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE = 2'd3;
	localparam logic [1:0] MODE_LIGHT = 2'd1;
	localparam logic [1:0] MODE_HEAVY = 2'd2;
	localparam logic [1:0] MODE_SPARE = 2'd3;

	localparam longint unsigned LN10_Q30_K   = 64'd2472381918;
	localparam longint unsigned LIGHT_THRESH = 64'd966367642;
	localparam longint unsigned HEAVY_THRESH = 64'd1395864371;
	localparam longint unsigned LIGHT_MAKEUP = 64'd2867;
	localparam longint unsigned HEAVY_MAKEUP = 64'd2048;
	localparam longint SAMPLE_MAX = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
	localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] left;
		logic signed [SAMPLE_BITS-1:0] right;
	} stereo_pair_t;

	logic                                clk = 1'b0;
	logic                                arst_n = 1'b0;
	logic                                cfg_wr_en = 1'b0;
	logic [CFG_INDEX_BITS-1:0]           cfg_index = '0;
	logic [CFG_DATA_BITS-1:0]            cfg_data = '0;
	logic                                in_valid = 1'b0;
	logic                                in_stall;
	logic signed [SAMPLE_BITS-1:0]       left_sample = '0;
	logic signed [SAMPLE_BITS-1:0]       right_sample = '0;
	logic                                out_valid;
	logic                                out_stall = 1'b0;
	logic signed [SAMPLE_BITS-1:0]       left_out;
	logic signed [SAMPLE_BITS-1:0]       right_out;

	// shadow of the block's registers and envelopes
	logic [1:0]       mode_shadow;
	logic [23:0]      attack_shadow;
	logic [23:0]      release_shadow;
	logic [31:0]      level_left;
	logic [31:0]      level_right;

	stereo_pair_t     pending_pairs[$];
	int               fail_count = 0;
	int               pairs_sent = 0;
	int               results_seen = 0;
	int               reg_writes = 0;
	int               cycle_count = 0;
	int               hold_requests = 0;
	int               hold_served = 0;
	int               hold_left = 0;
	bit               steady_tx = 1'b0;
	bit               steady_rx = 1'b0;

	stereo_upward_compressor u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.left_sample  (left_sample),
		.right_sample (right_sample),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.left_out     (left_out),
		.right_out    (right_out)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_top: done, errors");
			$finish;
		end
	end

	// exp(z), z and result in Q.30, by a truncated Taylor series
	function automatic longint unsigned exp_series_q30(longint unsigned z);
		longint unsigned total;
		longint unsigned term;
		int k;
		total = 64'd1 << 30;
		term = 64'd1 << 30;
		k = 1;
		while (k <= 24) begin
			term = ((term * z) >> 30) / k;
			if (term == 0)
				break;
			total += term;
			k++;
		end
		return total;
	endfunction

	function automatic longint unsigned boost_q12(longint unsigned idx, bit heavy);
		longint unsigned z;
		longint unsigned g;
		longint unsigned cap;
		if (heavy) begin
			z = (idx * LN10_Q30_K * 17) / 12;
			cap = 64'd20 << 12;
		end else begin
			z = (idx * LN10_Q30_K * 21) / 16;
			cap = 64'd12 << 12;
		end
		z = z >> GAIN_TABLE_BITS;
		g = (exp_series_q30(z) + (64'd1 << 17)) >> 18;
		return (g > cap) ? cap : g;
	endfunction

	function automatic longint unsigned upward_gain(logic [31:0] level, bit heavy);
		longint unsigned thr;
		longint unsigned makeup;
		longint unsigned gap;
		thr = heavy ? HEAVY_THRESH : LIGHT_THRESH;
		makeup = heavy ? HEAVY_MAKEUP : LIGHT_MAKEUP;
		if (level >= thr)
			return makeup;
		gap = (thr - level) >> (31 - GAIN_TABLE_BITS);
		return (boost_q12(gap, heavy) * makeup + 2048) >> 12;
	endfunction

	function automatic logic [31:0] track_level(logic [31:0] level, longint unsigned mag);
		longint unsigned c;
		logic [63:0] acc;
		c = (mag > level) ? attack_shadow : release_shadow;
		acc = c * level + ((64'd1 << 24) - c) * mag;
		return acc[55:24];
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] scale_and_clip(
			logic signed [SAMPLE_BITS-1:0] s, longint unsigned gain);
		longint p;
		longint q;
		p = longint'(s) * longint'(gain) + 2048;
		q = p >>> 12;
		if (q > SAMPLE_MAX)
			q = SAMPLE_MAX;
		if (q < SAMPLE_MIN)
			q = SAMPLE_MIN;
		return q[SAMPLE_BITS-1:0];
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] shape_channel(
			logic signed [SAMPLE_BITS-1:0] s, inout logic [31:0] level, input bit heavy);
		longint a;
		longint unsigned mag;
		a = longint'(s);
		if (a < 0)
			a = -a;
		mag = a;
		mag = mag << (32 - SAMPLE_BITS);
		level = track_level(level, mag);
		return scale_and_clip(s, upward_gain(level, heavy));
	endfunction

	function automatic stereo_pair_t compress_pair(stereo_pair_t x);
		stereo_pair_t y;
		bit heavy;
		if (mode_shadow == MODE_BYPASS)
			return x;
		heavy = (mode_shadow >= MODE_HEAVY);
		y.left = shape_channel(x.left, level_left, heavy);
		y.right = shape_channel(x.right, level_right, heavy);
		return y;
	endfunction

	// receiver: check each transaction, then choose the next stall
	always @(posedge clk) begin : rx_side
		stereo_pair_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				results_seen++;
				if (pending_pairs.size() == 0) begin
					$error("result with no pending pair: left_out %0d right_out %0d",
						left_out, right_out);
					fail_count++;
				end else begin
					want = pending_pairs.pop_front();
					if (left_out !== want.left) begin
						$error("left_out: expected %0d, got %0d", want.left, left_out);
						fail_count++;
					end
					if (right_out !== want.right) begin
						$error("right_out: expected %0d, got %0d", want.right, right_out);
						fail_count++;
					end
				end
			end
			if (hold_requests != hold_served) begin
				hold_served = hold_requests;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (!steady_rx && $urandom_range(0, 99) < 6)
				out_stall <= 1'b1;
			else
				out_stall <= 1'b0;
		end
	end

	task automatic send_pair(input logic signed [SAMPLE_BITS-1:0] l,
			input logic signed [SAMPLE_BITS-1:0] r);
		int gap;
		stereo_pair_t x;
		gap = 0;
		if (!steady_tx && $urandom_range(0, 99) < 6)
			gap = $urandom_range(1, 10);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		left_sample <= l;
		right_sample <= r;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		x.left = l;
		x.right = r;
		pending_pairs.push_back(compress_pair(x));
		pairs_sent++;
	endtask

	// hold the input off until every pending pair has come out
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_pairs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_MODE: mode_shadow = value[1:0];
			REG_ATTACK: attack_shadow = value;
			REG_RELEASE: release_shadow = value;
			default: ;
		endcase
		reg_writes++;
	endtask

	// random sample within +/- 2^span, or any code for a span of 23 and above
	function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(int span);
		logic [31:0] raw;
		logic signed [SAMPLE_BITS-1:0] v;
		raw = $urandom;
		if (span >= SAMPLE_BITS - 1)
			return raw[SAMPLE_BITS-1:0];
		v = SAMPLE_BITS'($urandom_range(0, (1 << span) - 1));
		return raw[31] ? -v : v;
	endfunction

	function automatic logic [23:0] pick_coeff();
		case ($urandom_range(0, 5))
			0: return 24'd0;
			1: return 24'hFFFFFF;
			2: return 24'(24'hFFFFFF - $urandom_range(0, 4095));
			3: return 24'(24'hFFFFFF - $urandom_range(0, 1 << 20));
			4: return 24'($urandom_range(0, 1 << 23));
			default: return 24'($urandom);
		endcase
	endfunction

	function automatic int pick_span();
		case ($urandom_range(0, 6))
			0: return 4;
			1: return 12;
			2: return 18;
			3: return 20;
			4: return 21;
			5: return 22;
			default: return 23;
		endcase
	endfunction

	task automatic send_random_pairs(input int count);
		int n;
		int burst;
		int span_l;
		int span_r;
		n = 0;
		while (n < count) begin
			burst = $urandom_range(4, 40);
			span_l = pick_span();
			span_r = ($urandom_range(0, 1) == 0) ? span_l : pick_span();
			while (burst > 0 && n < count) begin
				send_pair(pick_sample(span_l), pick_sample(span_r));
				burst--;
				n++;
			end
		end
	endtask

	task automatic test_bypass();
		send_pair(24'sd0, 24'sd0);
		send_pair(24'sh7FFFFF, 24'sh800000);
		send_pair(24'sh800000, 24'sh7FFFFF);
		send_pair(-24'sd1, 24'sd1);
		send_pair(pick_sample(23), pick_sample(23));
	endtask

	task automatic test_light_mode();
		drain_results();
		write_reg(REG_MODE, {22'd0, MODE_LIGHT});
		send_pair(24'sd0, 24'sd0);
		send_pair(24'sd1, -24'sd1);
		// low envelope: large boost drives both ends into saturation
		send_pair(24'sh7FFFFF, 24'sh800000);
		drain_results();
		write_reg(REG_ATTACK, 24'd0);
		send_pair(24'sh800000, 24'sh7FFFFF);
		send_pair(-24'sd1, 24'sd1);
		drain_results();
		write_reg(REG_RELEASE, 24'd0);
		send_pair(24'sh000100, -24'sh000100);
		send_pair(24'sh7FFFFF, 24'sh800000);
	endtask

	task automatic test_heavy_mode();
		drain_results();
		// upper data bits must not reach the mode field
		write_reg(REG_MODE, {22'h3FFFFF, MODE_HEAVY});
		write_reg(REG_ATTACK, 24'hFFFFFF);
		write_reg(REG_RELEASE, 24'hFFFFFF);
		send_pair(24'sh7FFFFF, 24'sh800000);
		send_pair(24'sh200000, -24'sh200000);
		drain_results();
		write_reg(REG_MODE, {22'd0, MODE_SPARE});
		write_reg(REG_ATTACK, 24'd0);
		send_pair(24'sh7FFFFF, -24'sh7FFFFF);
		send_pair(24'sh004000, -24'sh004000);
		drain_results();
		write_reg(REG_SPARE, CFG_DATA_BITS'($urandom));
		write_reg(REG_RELEASE, 24'd0);
		send_pair(24'sh800000, 24'sh800000);
		send_pair(24'sd0, 24'sd0);
	endtask

	task automatic test_random_settings();
		logic [1:0] modes[8];
		int p;
		modes = '{MODE_LIGHT, MODE_HEAVY, MODE_SPARE, MODE_BYPASS,
			MODE_LIGHT, MODE_HEAVY, MODE_LIGHT, MODE_HEAVY};
		for (p = 0; p < 8; p++) begin
			drain_results();
			write_reg(REG_MODE, {22'($urandom_range(0, (1 << 22) - 1)), modes[p]});
			if (p == 0) begin
				write_reg(REG_ATTACK, 24'd0);
				write_reg(REG_RELEASE, 24'hFFFFFF);
			end else if (p == 1) begin
				write_reg(REG_ATTACK, 24'hFFFFFF);
				write_reg(REG_RELEASE, 24'd0);
			end else begin
				write_reg(REG_ATTACK, pick_coeff());
				write_reg(REG_RELEASE, pick_coeff());
			end
			if ($urandom_range(0, 3) == 0)
				write_reg(REG_SPARE, CFG_DATA_BITS'($urandom));
			// one long stretch without idling on either side
			steady_tx = (p == 4);
			steady_rx = (p == 4);
			send_random_pairs(190);
		end
		steady_tx = 1'b0;
		steady_rx = 1'b0;
	endtask

	task automatic test_backpressure();
		drain_results();
		write_reg(REG_MODE, {22'd0, MODE_LIGHT});
		write_reg(REG_ATTACK, 24'hE00000);
		write_reg(REG_RELEASE, 24'hF00000);
		// receiver holds off while the sender keeps offering
		hold_requests++;
		send_random_pairs(40);
		drain_results();
		send_random_pairs(100);
	endtask

	initial begin
		mode_shadow = MODE_BYPASS;
		attack_shadow = 24'd16707456;
		release_shadow = 24'd16776342;
		level_left = '0;
		level_right = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_bypass();
		test_light_mode();
		test_heavy_mode();
		test_random_settings();
		test_backpressure();
		drain_results();

		$display("summary: %0d stereo pairs over %0d register writes, %0d results checked",
			pairs_sent, reg_writes, results_seen);
		$display("summary: bypass, light, heavy and spare modes; pole extremes; long hold-off");
		if (fail_count == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule

FILE: filelist.f
sv/suc_pkg.sv
sv/suc_gain_rom.sv
sv/suc_mul.sv
sv/stereo_upward_compressor.sv
test/tb_top.sv
